// ----- hdl/kol_pkg.sv -----
`timescale 1ns / 1ps

package kol_pkg;

  localparam int MAX_LEXEME_DEFAULT = 32;
  localparam int KW_COUNT           = 5;
  localparam int KW_SLOTS           = 8;

  // token codes
  localparam logic [6:0] CODE_NONE   = 7'd0;
  localparam logic [6:0] CODE_IDENT  = 7'd50;
  localparam logic [6:0] CODE_INT    = 7'd51;
  localparam logic [6:0] CODE_PLUS   = 7'd60;
  localparam logic [6:0] CODE_MINUS  = 7'd61;
  localparam logic [6:0] CODE_STAR   = 7'd62;
  localparam logic [6:0] CODE_SLASH  = 7'd63;
  localparam logic [6:0] CODE_ASSIGN = 7'd64;
  localparam logic [6:0] CODE_LT     = 7'd65;
  localparam logic [6:0] CODE_LE     = 7'd66;
  localparam logic [6:0] CODE_GT     = 7'd67;
  localparam logic [6:0] CODE_GE     = 7'd68;
  localparam logic [6:0] CODE_EQ     = 7'd69;
  localparam logic [6:0] CODE_NE     = 7'd70;
  localparam logic [6:0] CODE_LBRACE = 7'd71;
  localparam logic [6:0] CODE_RBRACE = 7'd72;
  localparam logic [6:0] CODE_LPAREN = 7'd73;
  localparam logic [6:0] CODE_RPAREN = 7'd74;
  localparam logic [6:0] CODE_COMMA  = 7'd75;
  localparam logic [6:0] CODE_SEMI   = 7'd76;

  // result status
  localparam logic [1:0] ST_TOKEN = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_HALT  = 2'd2;
  localparam logic [1:0] ST_END   = 2'd3;

  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_BANG = 8'h21;

  // keywords int, while, if, else, return; zero padded
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
    '{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd5, 3'd2, 3'd4, 3'd6};

  typedef enum logic [3:0] {
    CC_END,
    CC_SPACE,
    CC_ALPHA,
    CC_DIGIT,
    CC_LT,
    CC_GT,
    CC_EQ,
    CC_BANG,
    CC_OP,
    CC_BAD
  } char_class_t;

  typedef enum logic [2:0] {
    EK_RUN,
    EK_KW,
    EK_CODE,
    EK_OP,
    EK_END,
    EK_ERR
  } emit_kind_t;

  typedef struct packed {
    logic       load_char;
    logic       lex_begin;
    logic       lex_append;
    logic       idx_clr;
    logic       idx_inc;
    logic       emit;
    emit_kind_t kind;
    logic [6:0] code;
    logic       err_bang;
  } ctrl_cmd_t;

  typedef struct packed {
    char_class_t cls;
    logic        kw_hit;
    logic        run_last;
    logic        out_free;
  } dp_status_t;

  function automatic logic [6:0] op_code(input logic [7:0] c);
    logic [6:0] code;
    code = CODE_NONE;
    case (c)
      8'h2b:   code = CODE_PLUS;
      8'h2d:   code = CODE_MINUS;
      8'h2a:   code = CODE_STAR;
      8'h2f:   code = CODE_SLASH;
      8'h7b:   code = CODE_LBRACE;
      8'h7d:   code = CODE_RBRACE;
      8'h28:   code = CODE_LPAREN;
      8'h29:   code = CODE_RPAREN;
      8'h2c:   code = CODE_COMMA;
      8'h3b:   code = CODE_SEMI;
      default: code = CODE_NONE;
    endcase
    return code;
  endfunction

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t cls;
    priority if (c == CHAR_NUL) begin
      cls = CC_END;
    end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) begin
      cls = CC_SPACE;
    end else if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f) begin
      cls = CC_ALPHA;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cls = CC_DIGIT;
    end else if (c == 8'h3c) begin
      cls = CC_LT;
    end else if (c == 8'h3e) begin
      cls = CC_GT;
    end else if (c == 8'h3d) begin
      cls = CC_EQ;
    end else if (c == CHAR_BANG) begin
      cls = CC_BANG;
    end else if (op_code(c) != CODE_NONE) begin
      cls = CC_OP;
    end else begin
      cls = CC_BAD;
    end
    return cls;
  endfunction

endpackage

// ----- hdl/keyword_operator_lexer.sv -----
`timescale 1ns / 1ps
// Each character is registered and then dispatched; keyword and lookahead operator results are
//   emitted from dispatch, the others from the start-of-token step, and a flushed lexeme through
//   the registered store read, one character per read and emit step.
// in_stall holds off new requests until the sequencer is idle again, and a stalled output holds
//   the sequencer wherever it has a result to emit.
// Reset: synchronous; start state, zero length and overflow, out_valid low; store not cleared.

module keyword_operator_lexer #(
  parameter int MAX_LEXEME = kol_pkg::MAX_LEXEME_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  // character requests
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  // token requests
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] token_code,
  output logic [7:0] lexeme_char,
  output logic       has_char,
  output logic       last,
  output logic [1:0] status
);

  // commands from the sequencer, status back from the datapath
  kol_pkg::ctrl_cmd_t  cmd;
  kol_pkg::dp_status_t sts;

  // Sequencer: holds the scan mode (start, identifier, number, pending
  // lookahead on < > = !, halted) and walks each request through dispatch
  // and, where needed, lexeme flush and the start-of-token step.
  kol_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: character register, classifier, lexeme store with its length
  // and overflow flag, incremental keyword match, and the output register
  // that lets the sequencer run on while a result waits.
  kol_datapath #(
    .MAX_LEXEME (MAX_LEXEME)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ch          (ch),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .token_code  (token_code),
    .lexeme_char (lexeme_char),
    .has_char    (has_char),
    .last        (last),
    .status      (status)
  );

endmodule

// ----- hdl/kol_datapath.sv -----
`timescale 1ns / 1ps

module kol_datapath #(
  parameter int MAX_LEXEME = kol_pkg::MAX_LEXEME_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            ch,
  input  logic                  out_stall,
  input  kol_pkg::ctrl_cmd_t    cmd,
  output kol_pkg::dp_status_t   sts,
  output logic                  out_valid,
  output logic [6:0]            token_code,
  output logic [7:0]            lexeme_char,
  output logic                  has_char,
  output logic                  last,
  output logic [1:0]            status
);

  localparam int LW = $clog2(MAX_LEXEME + 1);
  localparam int AW = $clog2(MAX_LEXEME);

  logic [7:0]    char_q;
  logic [LW-1:0] len;
  logic          ovf;
  logic [kol_pkg::KW_COUNT-1:0] kw_live;
  logic [kol_pkg::KW_COUNT-1:0] kw_pos_ok;
  logic [AW-1:0] idx;
  logic [7:0]    rd_data;
  logic [7:0]    lex_mem [MAX_LEXEME];

  logic          room;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          kw_hit;
  logic [6:0]    kw_code;
  logic          run_last;
  logic          out_free;

  assign room     = len < LW'(MAX_LEXEME);
  assign wr_en    = cmd.lex_begin || (cmd.lex_append && room);
  assign wr_addr  = cmd.lex_begin ? '0 : len[AW-1:0];
  assign run_last = (LW'(idx) + LW'(1)) == len;
  assign out_free = !out_valid || !out_stall;

  // keyword prefix tracking at the current append position
  always_comb begin
    for (int k = 0; k < kol_pkg::KW_COUNT; k++) begin
      kw_pos_ok[k] = (len < LW'(kol_pkg::KW_LEN[k])) &&
                     (char_q == kol_pkg::KW_TEXT[k][len[2:0]]);
    end
  end

  always_comb begin
    kw_hit  = 1'b0;
    kw_code = kol_pkg::CODE_NONE;
    for (int k = 0; k < kol_pkg::KW_COUNT; k++) begin
      if (kw_live[k] && !ovf && len == LW'(kol_pkg::KW_LEN[k])) begin
        kw_hit  = 1'b1;
        kw_code = 7'(k + 1);
      end
    end
  end

  assign sts.cls      = kol_pkg::classify(char_q);
  assign sts.kw_hit   = kw_hit;
  assign sts.run_last = run_last;
  assign sts.out_free = out_free;

  // lexeme store: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      lex_mem[wr_addr] <= char_q;
    end
    rd_data <= lex_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      char_q <= ch;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      ovf     <= 1'b0;
      kw_live <= '0;
    end else if (cmd.lex_begin) begin
      len <= LW'(1);
      ovf <= 1'b0;
      for (int k = 0; k < kol_pkg::KW_COUNT; k++) begin
        kw_live[k] <= char_q == kol_pkg::KW_TEXT[k][0];
      end
    end else if (cmd.lex_append) begin
      if (room) begin
        len     <= len + LW'(1);
        kw_live <= kw_live & kw_pos_ok;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.kind)
        kol_pkg::EK_RUN: begin
          token_code  <= cmd.code;
          lexeme_char <= rd_data;
          has_char    <= 1'b1;
          last        <= run_last;
          status      <= ovf ? kol_pkg::ST_TRUNC : kol_pkg::ST_TOKEN;
        end
        kol_pkg::EK_KW: begin
          token_code  <= kw_code;
          lexeme_char <= kol_pkg::CHAR_NUL;
          has_char    <= 1'b0;
          last        <= 1'b1;
          status      <= kol_pkg::ST_TOKEN;
        end
        kol_pkg::EK_CODE: begin
          token_code  <= cmd.code;
          lexeme_char <= kol_pkg::CHAR_NUL;
          has_char    <= 1'b0;
          last        <= 1'b1;
          status      <= kol_pkg::ST_TOKEN;
        end
        kol_pkg::EK_OP: begin
          token_code  <= kol_pkg::op_code(char_q);
          lexeme_char <= kol_pkg::CHAR_NUL;
          has_char    <= 1'b0;
          last        <= 1'b1;
          status      <= kol_pkg::ST_TOKEN;
        end
        kol_pkg::EK_END: begin
          token_code  <= kol_pkg::CODE_NONE;
          lexeme_char <= kol_pkg::CHAR_NUL;
          has_char    <= 1'b0;
          last        <= 1'b1;
          status      <= kol_pkg::ST_END;
        end
        default: begin
          token_code  <= kol_pkg::CODE_NONE;
          lexeme_char <= cmd.err_bang ? kol_pkg::CHAR_BANG : char_q;
          has_char    <= 1'b1;
          last        <= 1'b1;
          status      <= kol_pkg::ST_HALT;
        end
      endcase
    end
  end

endmodule

// ----- hdl/kol_ctrl.sv -----
`timescale 1ns / 1ps

module kol_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  kol_pkg::dp_status_t sts,
  output kol_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DISP,
    PH_READ,
    PH_EMIT,
    PH_TAIL
  } phase_t;

  typedef enum logic [2:0] {
    M_START,
    M_IDENT,
    M_NUMBER,
    M_LT,
    M_GT,
    M_EQ,
    M_BANG,
    M_HALT
  } mode_t;

  phase_t phase, phase_next;
  mode_t  mode, mode_next;

  assign in_stall = phase != PH_IDLE;

  always_comb begin
    phase_next = phase;
    mode_next  = mode;
    cmd        = '0;
    cmd.kind   = kol_pkg::EK_CODE;
    cmd.code   = kol_pkg::CODE_NONE;
    unique case (phase)
      PH_IDLE: begin
        if (in_valid) begin
          cmd.load_char = 1'b1;
          phase_next    = PH_DISP;
        end
      end
      PH_DISP: begin
        unique case (mode)
          M_HALT: phase_next = PH_IDLE;
          M_START: phase_next = PH_TAIL;
          M_IDENT, M_NUMBER: begin
            if (sts.cls == kol_pkg::CC_DIGIT ||
                (mode == M_IDENT && sts.cls == kol_pkg::CC_ALPHA)) begin
              cmd.lex_append = 1'b1;
              phase_next     = PH_IDLE;
            end else if (mode == M_IDENT && sts.kw_hit) begin
              if (sts.out_free) begin
                cmd.emit   = 1'b1;
                cmd.kind   = kol_pkg::EK_KW;
                phase_next = PH_TAIL;
              end
            end else begin
              cmd.idx_clr = 1'b1;
              phase_next  = PH_READ;
            end
          end
          M_LT, M_GT, M_EQ: begin
            if (sts.out_free) begin
              cmd.emit = 1'b1;
              cmd.kind = kol_pkg::EK_CODE;
              if (sts.cls == kol_pkg::CC_EQ) begin
                cmd.code   = (mode == M_LT) ? kol_pkg::CODE_LE :
                             (mode == M_GT) ? kol_pkg::CODE_GE : kol_pkg::CODE_EQ;
                mode_next  = M_START;
                phase_next = PH_IDLE;
              end else begin
                cmd.code   = (mode == M_LT) ? kol_pkg::CODE_LT :
                             (mode == M_GT) ? kol_pkg::CODE_GT : kol_pkg::CODE_ASSIGN;
                phase_next = PH_TAIL;
              end
            end
          end
          default: begin
            // pending bang
            if (sts.out_free) begin
              cmd.emit   = 1'b1;
              phase_next = PH_IDLE;
              if (sts.cls == kol_pkg::CC_EQ) begin
                cmd.kind  = kol_pkg::EK_CODE;
                cmd.code  = kol_pkg::CODE_NE;
                mode_next = M_START;
              end else begin
                cmd.kind     = kol_pkg::EK_ERR;
                cmd.err_bang = 1'b1;
                mode_next    = M_HALT;
              end
            end
          end
        endcase
      end
      PH_READ: phase_next = PH_EMIT;
      PH_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = kol_pkg::EK_RUN;
          cmd.code = (mode == M_IDENT) ? kol_pkg::CODE_IDENT : kol_pkg::CODE_INT;
          if (sts.run_last) begin
            phase_next = PH_TAIL;
          end else begin
            cmd.idx_inc = 1'b1;
            phase_next  = PH_READ;
          end
        end
      end
      PH_TAIL: begin
        if (sts.out_free) begin
          phase_next = PH_IDLE;
          unique case (sts.cls)
            kol_pkg::CC_END: begin
              cmd.emit  = 1'b1;
              cmd.kind  = kol_pkg::EK_END;
              mode_next = M_START;
            end
            kol_pkg::CC_SPACE: mode_next = M_START;
            kol_pkg::CC_ALPHA: begin
              cmd.lex_begin = 1'b1;
              mode_next     = M_IDENT;
            end
            kol_pkg::CC_DIGIT: begin
              cmd.lex_begin = 1'b1;
              mode_next     = M_NUMBER;
            end
            kol_pkg::CC_LT:   mode_next = M_LT;
            kol_pkg::CC_GT:   mode_next = M_GT;
            kol_pkg::CC_EQ:   mode_next = M_EQ;
            kol_pkg::CC_BANG: mode_next = M_BANG;
            kol_pkg::CC_OP: begin
              cmd.emit  = 1'b1;
              cmd.kind  = kol_pkg::EK_OP;
              mode_next = M_START;
            end
            default: begin
              cmd.emit  = 1'b1;
              cmd.kind  = kol_pkg::EK_ERR;
              mode_next = M_HALT;
            end
          endcase
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      mode  <= M_START;
    end else begin
      phase <= phase_next;
      mode  <= mode_next;
    end
  end

endmodule
